// ----- design/float_to_decimal_text_unit_macros.svh -----
// ---------------------------------------------------------------------------
// float_to_decimal_text_unit_macros: assertion macros
// shared concurrent assertion forms for the float to decimal text unit
// ---------------------------------------------------------------------------
`ifndef FLOAT_TO_DECIMAL_TEXT_UNIT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_UNIT_MACROS_SVH

// same-cycle implication
`define FTDT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/ftdt_pkg.sv -----
// ---------------------------------------------------------------------------
// ftdt_pkg: float to decimal text package
// shared types and fixed constants of the float to decimal text unit
// ---------------------------------------------------------------------------
`default_nettype none

package ftdt_pkg;

   // integer part as ten bcd digits
   localparam int INT_DIGITS = 10;
   localparam int INT_IDX_W  = 4;
   localparam int BCD_W      = 4;
   localparam int BIN_W      = 32;

   // binary to bcd runs two bits a cycle
   localparam int DABBLE_CYCLES = BIN_W / 2;
   localparam int CONV_CNT_W    = 4;

   // configuration register
   localparam int             CSR_W                 = 3;
   localparam logic [CSR_W-1:0] FRACTION_DIGITS_RESET = 3'd2;

   // float decode
   localparam logic [7:0]  EXP_ALL_ONES  = 8'hFF;
   localparam logic [7:0]  EXP_SAT       = 8'd158;
   localparam logic [7:0]  SHIFT_BASE    = 8'd182;
   localparam logic [31:0] SAT_MAGNITUDE = 32'h7FFF_FFFF;

   // ascii codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;

   typedef logic [BCD_W-1:0] bcd_digit_type;
   typedef logic [INT_DIGITS-1:0][BCD_W-1:0] int_bcd_type;

   typedef struct packed {
      logic load;
      logic step;
   } dabble_ctrl_type;

endpackage

`default_nettype wire

// ----- design/float_to_decimal_text_unit.sv -----
// ---------------------------------------------------------------------------
// float_to_decimal_text_unit: ieee single to ascii decimal text
// prints a float as sign, integer digits, point and rounded fraction digits
// ---------------------------------------------------------------------------
// a number passes the conversion state, the fix state and then the print states;
// it prints as 1..19 characters, and no new number is taken until the last is out
// the conversion runs the binary to bcd shift register, two bits a cycle;
// fraction digits come from a x10 shifter, one digit a cycle, in parallel
// characters leave one per cycle and the receiver cannot stall them
// reset is synchronous: clears control and sets fraction_digits to 2
`default_nettype none

`include "float_to_decimal_text_unit_macros.svh"

module float_to_decimal_text_unit #(
   parameter int MAX_FRACTION_DIGITS = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic [31:0]                 req_value_bits,
   input  wire logic                        csr_write,
   input  wire logic [ftdt_pkg::CSR_W-1:0]  csr_fraction_digits,
   output      logic                        rsp_valid,
   output      logic [7:0]                  rsp_character,
   output      logic                        rsp_last_char
);

   localparam int DW = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int FW = MAX_FRACTION_DIGITS * ftdt_pkg::BCD_W;
   localparam logic [DW-1:0] MAX_D = DW'(MAX_FRACTION_DIGITS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_FIX   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_INT   = 3'd4;
   localparam logic [2:0] ST_POINT = 3'd5;
   localparam logic [2:0] ST_FRAC  = 3'd6;

   logic [2:0]                        state_ff, state_in;
   logic [ftdt_pkg::CONV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]                     fstep_ff, fstep_in;
   logic [DW-1:0]                     d_ff, d_in;
   logic [DW-1:0]                     fcnt_ff, fcnt_in;
   logic [31:0]                       frac_ff, frac_in;
   logic [FW-1:0]                     fbcd_ff, fbcd_in;
   logic                              round_ff, round_in;
   logic                              neg_ff, neg_in;
   ftdt_pkg::int_bcd_type             int_ff, int_in;
   logic [ftdt_pkg::INT_IDX_W-1:0]    idx_ff, idx_in;
   logic [ftdt_pkg::CSR_W-1:0]        fraction_digits_ff, fraction_digits_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_character_ff, rsp_character_in;
   logic                              rsp_last_char_ff, rsp_last_char_in;

   logic                              accept;
   logic                              emit_state;
   logic                              dec_sign;
   logic [7:0]                        dec_exp;
   logic [22:0]                       dec_man;
   logic                              dec_sat;
   logic [23:0]                       dec_sig;
   logic [7:0]                        dec_shift;
   logic [87:0]                       dec_wide;
   logic [31:0]                       dec_ipart;
   logic [31:0]                       dec_fpart;
   logic                              dec_neg;
   logic [DW-1:0]                     dec_d;
   logic [35:0]                       prod;
   logic [FW-1:0]                     frac_inc;
   logic                              frac_carry;
   ftdt_pkg::int_bcd_type             int_inc;
   logic [ftdt_pkg::INT_IDX_W-1:0]    int_top;
   ftdt_pkg::int_bcd_type             dabble_bcd;
   ftdt_pkg::dabble_ctrl_type         dabble_ctrl;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign emit_state = (state_ff == ST_SIGN) || (state_ff == ST_INT) ||
                       (state_ff == ST_POINT) || (state_ff == ST_FRAC);

   // float decode into 32.32 fixed point
   always_comb begin
      dec_sign  = req_value_bits[31];
      dec_exp   = req_value_bits[30:23];
      dec_man   = req_value_bits[22:0];
      dec_sat   = (dec_exp >= ftdt_pkg::EXP_SAT);
      dec_sig   = {(dec_exp != 8'd0), dec_man};
      dec_shift = ftdt_pkg::SHIFT_BASE - ((dec_exp != 8'd0) ? dec_exp : 8'd1);
      dec_wide  = {dec_sig, 64'd0} >> dec_shift;
      dec_ipart = dec_sat ? ftdt_pkg::SAT_MAGNITUDE : dec_wide[63:32];
      dec_fpart = dec_sat ? 32'd0 : dec_wide[31:0];
      dec_neg   = dec_sign && ((dec_exp == ftdt_pkg::EXP_ALL_ONES) ?
                               (dec_man == 23'd0) : (req_value_bits[30:0] != 31'd0));
      dec_d     = (32'(fraction_digits_ff) > 32'(MAX_FRACTION_DIGITS)) ?
                  MAX_D : DW'(fraction_digits_ff);
   end

   // fraction times ten, one digit per step
   assign prod = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);

   // rounding increment of the fraction digits, carry enters at digit d
   always_comb begin
      logic carry;
      logic nine;
      carry = 1'b0;
      frac_inc = fbcd_ff;
      for (int i = 0; i < MAX_FRACTION_DIGITS; i++) begin
         if (round_ff && (d_ff == DW'(MAX_FRACTION_DIGITS - i))) begin
            carry = 1'b1;
         end
         nine = (fbcd_ff[i*ftdt_pkg::BCD_W +: ftdt_pkg::BCD_W] == 4'd9);
         if (carry) begin
            frac_inc[i*ftdt_pkg::BCD_W +: ftdt_pkg::BCD_W] = nine ? 4'd0 :
               fbcd_ff[i*ftdt_pkg::BCD_W +: ftdt_pkg::BCD_W] + 4'd1;
         end
         carry = carry && nine;
      end
      frac_carry = carry;
   end

   // carry into the integer digits and leading digit search
   always_comb begin
      logic carry;
      logic nine;
      carry = frac_carry;
      int_inc = dabble_bcd;
      int_top = '0;
      for (int i = 0; i < ftdt_pkg::INT_DIGITS; i++) begin
         nine = (dabble_bcd[i] == 4'd9);
         if (carry) begin
            int_inc[i] = nine ? 4'd0 : dabble_bcd[i] + 4'd1;
         end
         carry = carry && nine;
      end
      for (int i = 0; i < ftdt_pkg::INT_DIGITS; i++) begin
         if (int_inc[i] != 4'd0) begin
            int_top = ftdt_pkg::INT_IDX_W'(i);
         end
      end
   end

   // integer part conversion
   assign dabble_ctrl.load = accept;
   assign dabble_ctrl.step = (state_ff == ST_CONV);

   ftdt_dabble u_dabble (
      .clock     (clock),
      .ctrl      (dabble_ctrl),
      .bin_value (dec_ipart),
      .bcd_value (dabble_bcd)
   );

   // sequencer: convert, round, then print one character per cycle
   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      fstep_in           = fstep_ff;
      d_in               = d_ff;
      fcnt_in            = fcnt_ff;
      frac_in            = frac_ff;
      fbcd_in            = fbcd_ff;
      round_in           = round_ff;
      neg_in             = neg_ff;
      int_in             = int_ff;
      idx_in             = idx_ff;
      fraction_digits_in = csr_write ? csr_fraction_digits : fraction_digits_ff;
      rsp_valid_in       = 1'b0;
      rsp_character_in   = rsp_character_ff;
      rsp_last_char_in   = rsp_last_char_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONV;
               cnt_in   = '0;
               fstep_in = '0;
               frac_in  = dec_fpart;
               neg_in   = dec_neg;
               d_in     = dec_d;
            end
         end
         ST_CONV: begin
            cnt_in = cnt_ff + 1'b1;
            if (fstep_ff == d_ff) begin
               round_in = (d_ff != '0) && frac_ff[31];
            end
            if (fstep_ff != MAX_D) begin
               frac_in  = prod[31:0];
               fbcd_in  = (fbcd_ff << ftdt_pkg::BCD_W) | FW'(prod[35:32]);
               fstep_in = fstep_ff + 1'b1;
            end
            if (cnt_ff == ftdt_pkg::CONV_CNT_W'(ftdt_pkg::DABBLE_CYCLES - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            fbcd_in  = frac_inc;
            int_in   = int_inc;
            idx_in   = int_top;
            fcnt_in  = d_ff;
            state_in = neg_ff ? ST_SIGN : ST_INT;
         end
         ST_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = ftdt_pkg::CH_MINUS;
            rsp_last_char_in = 1'b0;
            state_in         = ST_INT;
         end
         ST_INT: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = ftdt_pkg::CH_ZERO + {4'd0, int_ff[idx_ff]};
            rsp_last_char_in = (idx_ff == '0) && (d_ff == '0);
            if (idx_ff == '0) begin
               state_in = (d_ff != '0) ? ST_POINT : ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_POINT: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = ftdt_pkg::CH_POINT;
            rsp_last_char_in = 1'b0;
            state_in         = ST_FRAC;
         end
         ST_FRAC: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = ftdt_pkg::CH_ZERO +
                               {4'd0, fbcd_ff[FW-1 -: ftdt_pkg::BCD_W]};
            rsp_last_char_in = (fcnt_ff == DW'(1));
            fbcd_in          = fbcd_ff << ftdt_pkg::BCD_W;
            fcnt_in          = fcnt_ff - 1'b1;
            if (fcnt_ff == DW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         fraction_digits_ff <= ftdt_pkg::FRACTION_DIGITS_RESET;
      end else begin
         state_ff           <= state_in;
         rsp_valid_ff       <= rsp_valid_in;
         fraction_digits_ff <= fraction_digits_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      fstep_ff         <= fstep_in;
      d_ff             <= d_in;
      fcnt_ff          <= fcnt_in;
      frac_ff          <= frac_in;
      fbcd_ff          <= fbcd_in;
      round_ff         <= round_in;
      neg_ff           <= neg_in;
      int_ff           <= int_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last_char = rsp_last_char_ff;

   // checks
   `FTDT_ASSERT_NEXT(a_emit_strobes, clock, reset, emit_state, rsp_valid_ff)
   `FTDT_ASSERT_NEXT(a_no_stray_strobe, clock, reset, !emit_state, !rsp_valid_ff)
   `FTDT_ASSERT_SAME(a_last_frees_unit, clock, reset,
                     rsp_valid_ff && rsp_last_char_ff, !busy)
   `FTDT_ASSERT_SAME(a_digits_done, clock, reset, state_ff == ST_FIX, fstep_ff == MAX_D)
   `FTDT_ASSERT_NEXT(a_start_converts, clock, reset, accept, state_ff == ST_CONV)

endmodule

`default_nettype wire

// ----- design/ftdt_dabble.sv -----
// ---------------------------------------------------------------------------
// ftdt_dabble: serial binary to bcd converter
// shift-and-add-3 conversion of the integer part, two bits per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module ftdt_dabble (
   input  wire logic                              clock,
   input  wire ftdt_pkg::dabble_ctrl_type         ctrl,
   input  wire logic [ftdt_pkg::BIN_W-1:0]        bin_value,
   output      ftdt_pkg::int_bcd_type             bcd_value
);

   logic [ftdt_pkg::BIN_W-1:0] bin_ff, bin_in;
   ftdt_pkg::int_bcd_type      bcd_ff, bcd_in;

   // one shift-and-add-3 step
   function automatic ftdt_pkg::int_bcd_type dabble_bit(
      input ftdt_pkg::int_bcd_type bcd,
      input logic                  bit_in
   );
      ftdt_pkg::int_bcd_type adj;
      logic [ftdt_pkg::INT_DIGITS*ftdt_pkg::BCD_W-1:0] flat;
      adj = bcd;
      for (int i = 0; i < ftdt_pkg::INT_DIGITS; i++) begin
         if (adj[i] >= 4'd5) begin
            adj[i] = adj[i] + 4'd3;
         end
      end
      flat = adj;
      return {flat[ftdt_pkg::INT_DIGITS*ftdt_pkg::BCD_W-2:0], bit_in};
   endfunction

   // next value of the shift registers
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = bin_value;
         bcd_in = '0;
      end else if (ctrl.step) begin
         bin_in = bin_ff << 2;
         bcd_in = dabble_bit(dabble_bit(bcd_ff, bin_ff[ftdt_pkg::BIN_W-1]),
                             bin_ff[ftdt_pkg::BIN_W-2]);
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd_value = bcd_ff;

endmodule

`default_nettype wire

// ----- test/decimal_text_checker.sv -----
// ---------------------------------------------------------------------------
// decimal_text_checker: expected text store and compare for the float printer
// watches the csr, request and character channels of the float to decimal
// text unit, predicts each number's ascii text and checks every character
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module decimal_text_checker #(
   parameter int MAX_FRACTION_DIGITS = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [31:0]                 value_bits,
   input  wire logic                        csr_write,
   input  wire logic [ftdt_pkg::CSR_W-1:0]  csr_fraction_digits,
   input  wire logic                        rsp_valid,
   input  wire logic [7:0]                  rsp_character,
   input  wire logic                        rsp_last_char,
   output int                               failures,
   output int                               pending
);

   // exponent that puts the significand lsb at 2^-32 in the 32.32 layout
   localparam int FIXED_POINT_BIAS = 118;
   localparam int MAX_TEXT_CHARS   = 1 + ftdt_pkg::INT_DIGITS + 1 + MAX_FRACTION_DIGITS;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } text_char_type;

   text_char_type               expected_text_q [$];
   logic [ftdt_pkg::CSR_W-1:0]  fraction_digits_copy;
   int                          fail_count = 0;

   // render one float as its ascii text and queue the characters
   function automatic void predict_text(input logic [31:0] bits,
                                        input logic [ftdt_pkg::CSR_W-1:0] digits);
      logic          negative;
      logic [7:0]    exponent;
      logic [22:0]   mantissa;
      logic [63:0]   fixed_value;
      logic [63:0]   int_part;
      logic [31:0]   frac_part;
      logic [63:0]   scale;
      logic [63:0]   rounded;
      logic [63:0]   divisor;
      int            shift;
      int            frac_count;
      int            count;
      int            k;
      int            i;
      int            int_digit [ftdt_pkg::INT_DIGITS];
      logic [7:0]    text [MAX_TEXT_CHARS];
      text_char_type entry;

      exponent = bits[30:23];
      mantissa = bits[22:0];

      // decode into a 32.32 magnitude, saturating the big ones
      if (exponent == ftdt_pkg::EXP_ALL_ONES) begin
         int_part  = {32'd0, ftdt_pkg::SAT_MAGNITUDE};
         frac_part = '0;
         negative  = bits[31] && (mantissa == '0);
      end else if (exponent >= ftdt_pkg::EXP_SAT) begin
         int_part  = {32'd0, ftdt_pkg::SAT_MAGNITUDE};
         frac_part = '0;
         negative  = bits[31];
      end else begin
         fixed_value = {40'd0, (exponent != 8'd0), mantissa};
         shift = ((exponent != 8'd0) ? int'(exponent) : 1) - FIXED_POINT_BIAS;
         if (shift >= 0)
            fixed_value = fixed_value << shift;
         else if (-shift < 64)
            fixed_value = fixed_value >> (-shift);
         else
            fixed_value = '0;
         int_part  = fixed_value >> 32;
         frac_part = fixed_value[31:0];
         negative  = bits[31] && ((exponent != 8'd0) || (mantissa != '0));
      end

      frac_count = int'(digits);
      if (frac_count > MAX_FRACTION_DIGITS)
         frac_count = MAX_FRACTION_DIGITS;

      // round half up; a carry out of the fraction bumps the integer part
      scale   = 64'd1;
      rounded = '0;
      if (frac_count > 0) begin
         for (i = 0; i < frac_count; i++)
            scale = scale * 64'd10;
         rounded = ({32'd0, frac_part} * scale + 64'h8000_0000) >> 32;
         if (rounded >= scale) begin
            rounded  = rounded - scale;
            int_part = int_part + 64'd1;
         end
      end

      count = 0;
      if (negative) begin
         text[count] = ftdt_pkg::CH_MINUS;
         count++;
      end

      // integer digits, no leading zeros
      k = 0;
      do begin
         int_digit[k] = int'(int_part % 64'd10);
         int_part     = int_part / 64'd10;
         k++;
      end while (int_part != '0 && k < ftdt_pkg::INT_DIGITS);
      for (i = k - 1; i >= 0; i--) begin
         text[count] = ftdt_pkg::CH_ZERO + 8'(int_digit[i]);
         count++;
      end

      // point and zero-padded fraction digits
      if (frac_count > 0) begin
         text[count] = ftdt_pkg::CH_POINT;
         count++;
         divisor = scale / 64'd10;
         for (i = 0; i < frac_count; i++) begin
            text[count] = ftdt_pkg::CH_ZERO + 8'((rounded / divisor) % 64'd10);
            count++;
            divisor = divisor / 64'd10;
         end
      end

      for (i = 0; i < count; i++) begin
         entry.character = text[i];
         entry.last_char = (i == count - 1);
         expected_text_q.push_back(entry);
      end
   endfunction

   // watch all channels at each rising edge
   always @(posedge clock) begin
      text_char_type expected;

      if (reset) begin
         fraction_digits_copy = ftdt_pkg::FRACTION_DIGITS_RESET;
         expected_text_q.delete();
      end else begin
         // character transfer against the oldest expectation
         if (rsp_valid) begin
            if (expected_text_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected character %h last %b",
                           rsp_character, rsp_last_char);
            end else begin
               expected = expected_text_q.pop_front();
               if (rsp_character !== expected.character ||
                   rsp_last_char !== expected.last_char) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: char expected %h got %h, last expected %b got %b",
                              expected.character, rsp_character,
                              expected.last_char, rsp_last_char);
               end
            end
         end

         // csr write
         if (csr_write)
            fraction_digits_copy = csr_fraction_digits;

         // request transfer
         if (start && !busy)
            predict_text(value_bits, fraction_digits_copy);
      end

      failures <= fail_count;
      pending  <= expected_text_q.size();
   end

endmodule

// ----- test/float_to_decimal_text_unit_test.sv -----
// ---------------------------------------------------------------------------
// float_to_decimal_text_unit_test: testbench for the float to decimal text unit
// drives corner floats and shaped random floats under several fraction digit
// settings and sender idle rates; the checker predicts and compares the text
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module float_to_decimal_text_unit_test;

   localparam int LIMIT_CYCLES     = 200000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int ITEMS_PER_PHASE  = 42;
   localparam int PHASE_COUNT      = 8;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [31:0]                 req_value_bits = '0;
   logic                        csr_write = 1'b0;
   logic [ftdt_pkg::CSR_W-1:0]  csr_fraction_digits = '0;
   logic                        rsp_valid;
   logic [7:0]                  rsp_character;
   logic                        rsp_last_char;
   int                          failures;
   int                          pending;
   int                          idle_pct = 0;
   int                          cycle_count = 0;
   int                          digit_plan [PHASE_COUNT] = '{7, 0, 1, 3, 5, 4, 6, 2};

   // clock
   always #10 clock = ~clock;

   float_to_decimal_text_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value_bits      (req_value_bits),
      .csr_write           (csr_write),
      .csr_fraction_digits (csr_fraction_digits),
      .rsp_valid           (rsp_valid),
      .rsp_character       (rsp_character),
      .rsp_last_char       (rsp_last_char)
   );

   decimal_text_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .value_bits          (req_value_bits),
      .csr_write           (csr_write),
      .csr_fraction_digits (csr_fraction_digits),
      .rsp_valid           (rsp_valid),
      .rsp_character       (rsp_character),
      .rsp_last_char       (rsp_last_char),
      .failures            (failures),
      .pending             (pending)
   );

   // one request transfer, with random idle cycles ahead of it
   task automatic send_value(input logic [31:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_value_bits <= value;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every expected character is out, then let the unit settle
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fraction_digits(input logic [ftdt_pkg::CSR_W-1:0] digits);
      csr_write           <= 1'b1;
      csr_fraction_digits <= digits;
      @(posedge clock);
      csr_write           <= 1'b0;
   endtask

   // random float, weighted toward exponents that give printable digits
   function automatic logic [31:0] make_random_value();
      logic [7:0]  exponent;
      logic [22:0] mantissa;
      int          kind;

      kind     = $urandom_range(0, 9);
      mantissa = 23'($urandom);
      exponent = 8'($urandom_range(110, 160));
      case (kind)
         6: return $urandom;
         // decode boundaries: zero, inf/nan, saturation edge, near one
         7: begin
            case ($urandom_range(0, 5))
               0: exponent = 8'd0;
               1: exponent = 8'hFF;
               2: exponent = 8'd157;
               3: exponent = 8'd158;
               4: exponent = 8'd126;
               default: exponent = 8'd127;
            endcase
            if ($urandom_range(0, 1) == 0)
               mantissa = '0;
         end
         // x.999... values that push a rounding carry into the integer part
         8: begin
            exponent = 8'($urandom_range(120, 150));
            mantissa = 23'h7F_FFFF ^ 23'($urandom_range(0, 255));
         end
         // short mantissas: exact halves and ties
         9: begin
            exponent = 8'($urandom_range(115, 150));
            mantissa = mantissa & (23'h7F_FFFF << $urandom_range(8, 23));
         end
         default: ;
      endcase
      return {1'($urandom), exponent, mantissa};
   endfunction

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int phase;
      int n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corner values at the reset setting of two fraction digits
      idle_pct = 36;
      send_value(32'h0000_0000);   // positive zero
      send_value(32'h8000_0000);   // negative zero, no sign
      send_value(32'h3F80_0000);   // 1.0
      send_value(32'hBF80_0000);   // -1.0
      send_value(32'h7F80_0000);   // +inf saturates
      send_value(32'hFF80_0000);   // -inf keeps the sign
      send_value(32'h7FC0_0000);   // nan
      send_value(32'hFFC0_0000);   // negative nan, still no sign
      send_value(32'h7F7F_FFFF);   // largest finite
      send_value(32'hFF7F_FFFF);
      send_value(32'h4F00_0000);   // exactly 2^31
      send_value(32'h4EFF_FFFF);   // just under 2^31
      send_value(32'hCEFF_FFFF);
      send_value(32'h0000_0001);   // smallest subnormal
      send_value(32'h8000_0001);   // tiny negative prints a sign
      send_value(32'h007F_FFFF);   // largest subnormal
      send_value(32'h2F80_0000);   // 2^-32, lowest kept bit
      send_value(32'hAF00_0000);   // 2^-33 dropped, sign kept
      send_value(32'h3C23_D70A);   // 0.01
      send_value(32'h3E00_0000);   // 0.125, tie rounds up
      send_value(32'h3F00_0000);   // 0.5
      send_value(32'h3F7F_F972);   // 0.9999 carries to 1.00
      send_value(32'hBF7F_FFFF);   // -0.99999994 carries
      send_value(32'h4049_0FDB);   // pi
      drain_results();

      // random phases across digit settings and sender idle rates
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 3)
            idle_pct = 36;
         else if (phase < 6)
            idle_pct = 56;
         else
            idle_pct = 0;
         write_fraction_digits(digit_plan[phase][ftdt_pkg::CSR_W-1:0]);
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_value(make_random_value());
         drain_results();
      end

      if (failures == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
